@@ design/depq_pkg.sv @@
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and constants of the double-ended priority queue unit.
// ----------------------------------------------------------------------------
package depq_pkg;

   // Default number of values the store can hold.
   localparam int DepqCapacity = 64;

   // Width of a stored value and of the reported entry count.
   localparam int DataWidth  = 32;
   localparam int CountWidth = 7;

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_POP_MIN = 2'd1,
      OP_POP_MAX = 2'd2
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_RD,
      ST_INS_SH,
      ST_FETCH,
      ST_CAPTURE,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;     // capture the accepted item
      logic ins_start; // start an insert at the top of the store
      logic rd_shift;  // read the entry below the insert position
      logic shift;     // move that entry up one place
      logic place;     // write the new value at the insert position
      logic pop_min;   // drop the smallest value
      logic pop_max;   // drop the largest value
      logic rd_min;    // read the new smallest value
      logic rd_max;    // read the new largest value
      logic cap_min;   // load the read data as the minimum
      logic cap_max;   // load the read data as the maximum
      logic set_drop;  // flag a refused insert
      logic load_rsp;  // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;       // operation of the item in hand
      logic       full;     // store holds its capacity
      logic       empty;    // store holds nothing
      logic       last_one; // store holds exactly one value
      logic       pos_zero; // insert position has reached the bottom
      logic       shift_gt; // entry read is greater than the new value
   } status_type;

endpackage

@@ design/depq_req_if.sv @@
// ----------------------------------------------------------------------------
// depq_req_if
// Input channel: an operation and a value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface depq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           op;
   logic signed [depq_pkg::DataWidth-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

@@ design/depq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// depq_rsp_if
// Result channel: extremes, count and flags with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface depq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [depq_pkg::DataWidth-1:0] max_value;
   logic signed [depq_pkg::DataWidth-1:0] min_value;
   logic                                  is_empty;
   logic [depq_pkg::CountWidth-1:0]       entry_count;
   logic                                  dropped;

   modport source (output valid, output max_value, output min_value, output is_empty,
                   output entry_count, output dropped, input ready);
   modport sink   (input valid, input max_value, input min_value, input is_empty,
                   input entry_count, input dropped, output ready);
endinterface

@@ design/depq_ram.sv @@
// ----------------------------------------------------------------------------
// depq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module depq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/depq_dp.sv @@
// ----------------------------------------------------------------------------
// depq_dp
// Datapath: circular sorted store in RAM, head and count pointers, cached
// extremes and the result register.
// ----------------------------------------------------------------------------
module depq_dp #(
   parameter int CAPACITY = depq_pkg::DepqCapacity
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  depq_pkg::cmd_type                     cmd,
   input  logic [1:0]                            req_op,
   input  logic signed [depq_pkg::DataWidth-1:0] req_value,
   output depq_pkg::status_type                  status,
   output logic signed [depq_pkg::DataWidth-1:0] rsp_max_value,
   output logic signed [depq_pkg::DataWidth-1:0] rsp_min_value,
   output logic                                  rsp_is_empty,
   output logic [depq_pkg::CountWidth-1:0]       rsp_entry_count,
   output logic                                  rsp_dropped
);
   import depq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW:0]   CapWide  = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
   localparam logic [AW-1:0] LastAddr = AW'(CAPACITY - 1);

   // Physical address of a logical position counted from the head.
   function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CapWide) begin
         sum = sum - CapWide;
      end
      return sum[AW-1:0];
   endfunction

   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [1:0]                    op_ff;
   logic signed [DataWidth-1:0]   val_ff;
   logic signed [DataWidth-1:0]   min_ff, min_in;
   logic signed [DataWidth-1:0]   max_ff, max_in;
   logic                          drop_ff;
   logic signed [DataWidth-1:0]   rsp_max_ff, rsp_min_ff;
   logic                          rsp_empty_ff, rsp_drop_ff;
   logic [CountWidth-1:0]         rsp_count_ff;

   logic                          wr_en, rd_en;
   logic [AW-1:0]                 wr_addr, rd_addr;
   logic [DataWidth-1:0]          wr_data, rd_data;
   logic signed [DataWidth-1:0]   rd_value;

   assign rd_value = $signed(rd_data);

   // Store access.
   always_comb begin
      wr_en   = cmd.shift | cmd.place;
      wr_addr = wrap_addr(head_ff, pos_ff);
      wr_data = cmd.shift ? rd_data : val_ff;
      rd_en   = cmd.rd_shift | cmd.rd_min | cmd.rd_max;
      rd_addr = wrap_addr(head_ff, AW'(count_ff - 1'b1));
      if (cmd.rd_shift) begin
         rd_addr = wrap_addr(head_ff, pos_ff - 1'b1);
      end else if (cmd.rd_min) begin
         rd_addr = head_ff;
      end
   end

   depq_ram #(
      .WIDTH (DataWidth),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pointer and extreme updates.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      pos_in   = pos_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (cmd.ins_start) begin
         pos_in = AW'(count_ff);
      end
      if (cmd.shift) begin
         pos_in = pos_ff - 1'b1;
      end
      if (cmd.place) begin
         count_in = count_ff + 1'b1;
         if (count_ff == '0) begin
            min_in = val_ff;
            max_in = val_ff;
         end else begin
            min_in = (val_ff < min_ff) ? val_ff : min_ff;
            max_in = (val_ff > max_ff) ? val_ff : max_ff;
         end
      end
      if (cmd.pop_min) begin
         count_in = count_ff - 1'b1;
         head_in  = (head_ff == LastAddr) ? '0 : head_ff + 1'b1;
      end
      if (cmd.pop_max) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.cap_min) begin
         min_in = rd_value;
      end
      if (cmd.cap_max) begin
         max_in = rd_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         if (cmd.latch) begin
            drop_ff <= 1'b0;
         end else if (cmd.set_drop) begin
            drop_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      min_ff <= min_in;
      max_ff <= max_in;
      if (cmd.latch) begin
         op_ff  <= req_op;
         val_ff <= req_value;
      end
      if (cmd.load_rsp) begin
         rsp_max_ff   <= (count_ff == '0) ? '0 : max_ff;
         rsp_min_ff   <= (count_ff == '0) ? '0 : min_ff;
         rsp_empty_ff <= (count_ff == '0);
         rsp_count_ff <= CountWidth'(count_ff);
         rsp_drop_ff  <= drop_ff;
      end
   end

   always_comb begin
      status.op       = op_ff;
      status.full     = (count_ff == CapCount);
      status.empty    = (count_ff == '0);
      status.last_one = (count_ff == CW'(1));
      status.pos_zero = (pos_ff == '0);
      status.shift_gt = (rd_value > val_ff);
   end

   assign rsp_max_value   = rsp_max_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_dropped     = rsp_drop_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount)
      else $error("Entry count exceeds the capacity.");

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> (count_ff != CapCount))
      else $error("Value written into a full store.");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_min || cmd.pop_max) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("Removal did not lower the count by one.");

   a_shift_above_bottom: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> (pos_ff != '0))
      else $error("Shift attempted below the head of the store.");
`endif

endmodule

@@ design/depq_ctrl.sv @@
// ----------------------------------------------------------------------------
// depq_ctrl
// Controller: sequences one item through the datapath and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module depq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  depq_pkg::status_type status,
   output depq_pkg::cmd_type    cmd
);
   import depq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            // No item is taken while reset is held.
            req_ready = ~reset;
            if (req_valid && !reset) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               OP_INSERT: begin
                  if (status.full) begin
                     cmd.set_drop = 1'b1;
                     state_in     = ST_RESULT;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = ST_INS_RD;
                  end
               end
               OP_POP_MIN: begin
                  if (status.empty) begin
                     state_in = ST_RESULT;
                  end else begin
                     cmd.pop_min = 1'b1;
                     state_in    = status.last_one ? ST_RESULT : ST_FETCH;
                  end
               end
               OP_POP_MAX: begin
                  if (status.empty) begin
                     state_in = ST_RESULT;
                  end else begin
                     cmd.pop_max = 1'b1;
                     state_in    = status.last_one ? ST_RESULT : ST_FETCH;
                  end
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_INS_RD: begin
            if (status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_RESULT;
            end else begin
               cmd.rd_shift = 1'b1;
               state_in     = ST_INS_SH;
            end
         end
         ST_INS_SH: begin
            if (status.shift_gt) begin
               cmd.shift = 1'b1;
               state_in  = ST_INS_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_RESULT;
            end
         end
         ST_FETCH: begin
            if (status.op == OP_POP_MIN) begin
               cmd.rd_min = 1'b1;
            end else begin
               cmd.rd_max = 1'b1;
            end
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            if (status.op == OP_POP_MIN) begin
               cmd.cap_min = 1'b1;
            end else begin
               cmd.cap_max = 1'b1;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_load_only_in_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (state_ff == ST_RESULT))
      else $error("Result register loaded outside the result state.");

   a_latch_leads_to_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> (state_ff == ST_DECODE))
      else $error("Accepted item was not decoded next.");

   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.shift && cmd.place))
      else $error("Shift and place issued together.");
`endif

endmodule

@@ design/double_ended_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Bounded double-ended priority queue of signed 32-bit values.
// ----------------------------------------------------------------------------
// The unit keeps up to CAPACITY signed values, duplicates allowed, sorted in
// ascending order in a single RAM used as a circular buffer: the smallest
// value sits at the head pointer and the largest at head plus count less one.
// Each item on the request channel inserts a value, removes the smallest or
// removes the largest; one result item follows every request item and
// reports the largest and smallest values held (both zero when empty), the
// count and whether an insert was refused because the store was full.
// Removal on an empty store and the unused operation code leave the store
// unchanged. The minimum and maximum are cached in registers, so a removal
// at either end only moves a pointer and reads back one entry; an insert
// walks down from the top, reading and comparing one entry per step through
// the RAM's single read and write ports. A result still waiting in the
// output register holds the item in the result state until it is taken.
// The next request item is accepted while an earlier result still waits in
// the output register. The RAM is not cleared after reset; only entries
// inside the held range are ever read.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit #(
   parameter int CAPACITY = depq_pkg::DepqCapacity
) (
   input  logic        clock,
   input  logic        reset,
   depq_req_if.sink    req_if,
   depq_rsp_if.source  rsp_if
);
   import depq_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: walks each item through decode, insert steps or the
   // read-back of a new extreme, and loads the result register.
   depq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the sorted store, its pointers, the cached extremes and the
   // result payload.
   depq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_if.op),
      .req_value       (req_if.value),
      .status          (status),
      .rsp_max_value   (rsp_if.max_value),
      .rsp_min_value   (rsp_if.min_value),
      .rsp_is_empty    (rsp_if.is_empty),
      .rsp_entry_count (rsp_if.entry_count),
      .rsp_dropped     (rsp_if.dropped)
   );

endmodule

@@ sim/tb_double_ended_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_priority_queue_unit
// Self-checking bench for the double-ended priority queue unit.
// ----------------------------------------------------------------------------
// A shadow of the sorted store is kept alongside the block. Every item taken
// on the request channel is applied to the shadow, and the report it should
// produce is queued. Each report on the result channel is checked field by
// field against the oldest queued report. The stimulus opens with a directed
// sequence, covering the value extremes, duplicates, the unused operation code
// and removals from an empty store. It then runs random bursts that fill the
// store past capacity, drain it past empty, or mix the two. Both channels
// stall at random, apart from one long stretch where neither does.
// ----------------------------------------------------------------------------
module tb_double_ended_priority_queue_unit;
   import depq_pkg::*;

   localparam int                          ClockHalf    = 5;
   localparam int                          ResetCycles  = 9;
   localparam int                          IdlePercent  = 23;
   localparam int                          RandomItems  = 1300;
   localparam int                          SteadyFrom   = 500;
   localparam int                          SteadyTo     = 800;
   localparam int                          DrainCycles  = 2 * DepqCapacity + 8;
   localparam int                          CycleLimit   = 600000;
   localparam logic [1:0]                  OP_UNUSED    = 2'd3;
   localparam logic signed [DataWidth-1:0] ValueMin     = 32'sh8000_0000;
   localparam logic signed [DataWidth-1:0] ValueMax     = 32'sh7FFF_FFFF;
   localparam int                          BurstFill    = 0;
   localparam int                          BurstDrain   = 1;
   localparam int                          BurstMixed   = 2;

   typedef struct {
      logic signed [DataWidth-1:0] max_value;
      logic signed [DataWidth-1:0] min_value;
      logic                        is_empty;
      logic [CountWidth-1:0]       entry_count;
      logic                        dropped;
   } report_type;

   // Shadow of the sorted store and the reports it still owes.
   class depq_shadow;
      logic signed [DataWidth-1:0] sorted_store [DepqCapacity];
      int                          held;
      report_type                  owed_reports [$];
      int                          mismatches;

      function new();
         held       = 0;
         mismatches = 0;
      endfunction

      // Applies one accepted item and queues the report it must give.
      function void apply_item(logic [1:0] op, logic signed [DataWidth-1:0] value);
         report_type want;
         int         pos;
         want.dropped = 1'b0;
         case (op)
            OP_INSERT: begin
               if (held >= DepqCapacity) begin
                  want.dropped = 1'b1;
               end else begin
                  // New value goes above any equal values already held.
                  pos = held;
                  while (pos > 0 && sorted_store[pos-1] > value) begin
                     sorted_store[pos] = sorted_store[pos-1];
                     pos--;
                  end
                  sorted_store[pos] = value;
                  held++;
               end
            end
            OP_POP_MIN: begin
               if (held > 0) begin
                  for (int i = 1; i < held; i++) sorted_store[i-1] = sorted_store[i];
                  held--;
               end
            end
            OP_POP_MAX: begin
               if (held > 0) held--;
            end
            default: ;
         endcase
         if (held == 0) begin
            want.max_value = '0;
            want.min_value = '0;
            want.is_empty  = 1'b1;
         end else begin
            want.max_value = sorted_store[held-1];
            want.min_value = sorted_store[0];
            want.is_empty  = 1'b0;
         end
         want.entry_count = held[CountWidth-1:0];
         owed_reports.push_back(want);
      endfunction

      function void compare_field(string name, logic [DataWidth-1:0] want,
                                  logic [DataWidth-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // Checks one report from the block against the oldest one owed.
      function void check_report(report_type got);
         report_type want;
         if (owed_reports.size() == 0) begin
            $display("%0t: report with no item outstanding, actual max %h min %h count %0d",
                     $time, got.max_value, got.min_value, got.entry_count);
            mismatches++;
            return;
         end
         want = owed_reports.pop_front();
         compare_field("max_value", want.max_value, got.max_value);
         compare_field("min_value", want.min_value, got.min_value);
         compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
         compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
         compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       steady_run;
   int         fill_level;
   int         sent_items;
   int         cycle_count;
   depq_shadow board;

   depq_req_if req_ch ();
   depq_rsp_if rsp_ch ();

   double_ended_priority_queue_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockHalf) clock = ~clock;
   end

   // Offers one item, with random gaps first, and returns once it is taken.
   // A rough fill level is kept so that the opening can drain the store.
   task automatic send_item(input logic [1:0] op, input logic signed [DataWidth-1:0] value);
      while (!steady_run && $urandom_range(99) < IdlePercent) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
      if (op == OP_INSERT) begin
         if (fill_level < DepqCapacity) fill_level++;
      end else if (op != OP_UNUSED && fill_level > 0) begin
         fill_level--;
      end
   endtask

   // Extremes and a narrow band for duplicates, otherwise any value.
   function automatic logic signed [DataWidth-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)  return ValueMin;
      if (roll < 16) return ValueMax;
      if (roll < 45) return DataWidth'(int'($urandom_range(16)) - 8);
      return $urandom;
   endfunction

   // Result side: ready drops at random outside the steady stretch.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && (steady_run || $urandom_range(99) >= IdlePercent);
      end
   end

   // Both handshakes are sampled at the rising edge.
   initial begin
      board = new();
      forever begin
         @(posedge clock);
         if (!reset && req_ch.valid && req_ch.ready) board.apply_item(req_ch.op, req_ch.value);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            board.check_report('{max_value:   rsp_ch.max_value,
                                 min_value:   rsp_ch.min_value,
                                 is_empty:    rsp_ch.is_empty,
                                 entry_count: rsp_ch.entry_count,
                                 dropped:     rsp_ch.dropped});
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_double_ended_priority_queue_unit failed");
      $finish;
   end

   initial begin
      logic [1:0] op;
      int         burst_mode;
      int         burst_len;
      int         roll;

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_INSERT;
      req_ch.value <= '0;
      steady_run    = 1'b0;
      fill_level    = 0;
      sent_items    = 0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty removals, extremes, duplicates, unused code.
      send_item(OP_POP_MIN, 32'sd0);
      send_item(OP_POP_MAX, 32'sd0);
      send_item(OP_UNUSED, ValueMax);
      send_item(OP_INSERT, ValueMax);
      send_item(OP_INSERT, ValueMin);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sd1);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, ValueMax);
      send_item(OP_INSERT, ValueMin);
      send_item(OP_UNUSED, ValueMin);
      send_item(OP_POP_MAX, ValueMax);
      send_item(OP_POP_MIN, ValueMin);
      send_item(OP_INSERT, ValueMin + 32'sd1);
      send_item(OP_INSERT, ValueMax - 32'sd1);
      while (fill_level > 0) begin
         send_item(($urandom_range(1) != 0) ? OP_POP_MIN : OP_POP_MAX, pick_value());
      end
      send_item(OP_POP_MAX, ValueMin);
      send_item(OP_POP_MIN, ValueMax);

      // Hold off until every report of the opening sequence has arrived.
      // It waits on the clock first, so the last item taken is already owed.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.owed_reports.size() != 0) @(posedge clock);

      // Random bursts: filling runs past capacity, draining runs past empty.
      sent_items = 0;
      while (sent_items < RandomItems) begin
         burst_mode = $urandom_range(BurstMixed, BurstFill);
         burst_len  = $urandom_range(100, 70);
         repeat (burst_len) begin
            if (sent_items >= RandomItems) break;
            steady_run = (sent_items >= SteadyFrom && sent_items < SteadyTo);
            roll = $urandom_range(99);
            case (burst_mode)
               BurstFill:  op = (roll < 94) ? OP_INSERT  : (roll < 96) ? OP_POP_MIN :
                                (roll < 98) ? OP_POP_MAX : OP_UNUSED;
               BurstDrain: op = (roll < 45) ? OP_POP_MIN : (roll < 90) ? OP_POP_MAX :
                                (roll < 96) ? OP_INSERT  : OP_UNUSED;
               default:    op = (roll < 50) ? OP_INSERT  : (roll < 72) ? OP_POP_MIN :
                                (roll < 94) ? OP_POP_MAX : OP_UNUSED;
            endcase
            send_item(op, pick_value());
         end
      end
      steady_run = 1'b0;
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (board.owed_reports.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.mismatches == 0 && board.owed_reports.size() == 0) begin
         $display("tb_double_ended_priority_queue_unit passed");
      end else begin
         $display("tb_double_ended_priority_queue_unit failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/depq_pkg.sv
design/depq_req_if.sv
design/depq_rsp_if.sv
design/depq_ram.sv
design/depq_dp.sv
design/depq_ctrl.sv
design/double_ended_priority_queue_unit.sv
sim/tb_double_ended_priority_queue_unit.sv
